// ----- hdl/interval_binary_search_assert.svh -----
// Assertion macros used by the interval search RTL
`ifndef INTERVAL_BINARY_SEARCH_ASSERT_SVH
`define INTERVAL_BINARY_SEARCH_ASSERT_SVH

// same-cycle implication
`define IBS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ibs: assertion failed");

// next-cycle implication
`define IBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ibs: assertion failed");

`endif

// ----- hdl/ibs_pkg.sv -----
// Constants, codes and interface types of the interval search block
package ibs_pkg;

   localparam int TARGET_COUNT       = 16;
   localparam int ENTRIES_PER_TARGET = 256;
   localparam int TGT_W              = $clog2(TARGET_COUNT);
   localparam int IDX_W              = $clog2(ENTRIES_PER_TARGET);
   localparam int CNT_W              = IDX_W + 1;
   localparam int KEY_W              = 64;
   localparam int ADDR_W             = TGT_W + IDX_W;
   localparam int STORE_DEPTH        = TARGET_COUNT * ENTRIES_PER_TARGET;

   localparam int TGT_LSB     = 0;
   localparam int SLOT_LSB    = TGT_LSB + TGT_W;
   localparam int KEY_LSB     = SLOT_LSB + IDX_W;
   localparam int CNT_LSB     = KEY_LSB + KEY_W;
   localparam int REQ_BITS    = CNT_LSB + CNT_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((IDX_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_COUNT = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_SHORT = 2'd2,
      ST_OOB   = 2'd3
   } status_type;

   typedef struct packed {
      logic              start;
      logic              wr_en;
      logic [TGT_W-1:0]  target;
      logic [IDX_W-1:0]  index;
      logic [KEY_W-1:0]  key;
   } ibs_req_type;

   typedef struct packed {
      logic              done;
      logic              oob;
      logic [IDX_W-1:0]  found;
   } ibs_res_type;

endpackage

// ----- hdl/ibs_search.sv -----
// Breakpoint memory and the halving search sequencer
`include "interval_binary_search_assert.svh"

module ibs_search (
   input  logic                clock,
   input  logic                reset,
   input  ibs_pkg::ibs_req_type req,
   output logic                busy,
   output ibs_pkg::ibs_res_type res
);
   import ibs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LO   = 4'b0010,
      S_HI   = 4'b0100,
      S_MID  = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [KEY_W-1:0]        mem [STORE_DEPTH];
   logic signed [KEY_W-1:0] rdata_ff;
   logic signed [KEY_W-1:0] time_ff, time_in;
   logic signed [KEY_W-1:0] key_lo_ff, key_lo_in;
   logic [TGT_W-1:0]        tgt_ff, tgt_in;
   logic [IDX_W-1:0]        lo_ff, lo_in;
   logic [IDX_W-1:0]        hi_ff, hi_in;
   logic [IDX_W-1:0]        mid_ff, mid_in;
   logic [ADDR_W-1:0]       raddr;
   logic [IDX_W:0]          mid_sum;
   logic                    in_range;
   logic                    go_on;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      tgt_in    = tgt_ff;
      time_in   = time_ff;
      key_lo_in = key_lo_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      raddr     = {tgt_ff, mid_ff};
      res       = '0;
      in_range  = (key_lo_ff <= time_ff) && (time_ff < rdata_ff);

      unique case (state_ff)
         S_IDLE: begin
            raddr = {req.target, IDX_W'(0)};
            if (req.start) begin
               state_in = S_LO;
               tgt_in   = req.target;
               time_in  = req.key;
               lo_in    = '0;
               hi_in    = req.index;
            end
         end
         S_LO: begin
            raddr     = {tgt_ff, hi_ff};
            key_lo_in = rdata_ff;
            state_in  = S_HI;
         end
         S_HI: begin
         end
         S_MID: begin
            if (in_range) begin
               hi_in = mid_ff;
            end else begin
               lo_in     = mid_ff;
               key_lo_in = rdata_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      mid_sum = {1'b0, lo_in} + {1'b0, hi_in};
      go_on   = (mid_sum[IDX_W:1] != lo_in) && (mid_sum[IDX_W:1] != hi_in);

      if (state_ff == S_HI && !in_range) begin
         res.done = 1'b1;
         res.oob  = 1'b1;
         state_in = S_IDLE;
      end else if (state_ff == S_HI || state_ff == S_MID) begin
         raddr  = {tgt_ff, mid_sum[IDX_W:1]};
         mid_in = mid_sum[IDX_W:1];
         if (go_on) begin
            state_in = S_MID;
         end else begin
            state_in  = S_IDLE;
            res.done  = 1'b1;
            res.found = lo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff    <= tgt_in;
      time_ff   <= time_in;
      key_lo_ff <= key_lo_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[{req.target, req.index}] <= req.key;
      end
      rdata_ff <= mem[raddr];
   end

   `IBS_ASSERT_IMPL(a_req_when_idle, clock, reset, req.start || req.wr_en, state_ff == S_IDLE)
   `IBS_ASSERT_IMPL(a_mid_inside, clock, reset, state_ff == S_MID, lo_ff < mid_ff && mid_ff < hi_ff)
   `IBS_ASSERT_NEXT(a_done_idle, clock, reset, res.done, state_ff == S_IDLE)
   `IBS_ASSERT_IMPL(a_oob_zero, clock, reset, res.oob, res.done && res.found == '0)

endmodule

// ----- hdl/interval_binary_search.sv -----
// Query: the first and last entries of the target are read, then one memory probe
//   per halving step (at most log2 of the entry count) on a single read port.
// Write, count and unused opcodes: result one cycle after acceptance, one item a cycle.
// A new item is taken once the search is idle and the result register is free.
// Synchronous reset clears entry counts and control; breakpoints are not cleared.
module interval_binary_search (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ibs_pkg::REQ_TDATA_W-1:0]  req_tdata,  // target, slot, key, entry_count, pad
   input  logic [1:0]                       req_tuser,  // opcode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ibs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // found_index
   output logic [1:0]                       rsp_tuser   // status
);
   import ibs_pkg::*;

   opcode_type          op;
   logic [TGT_W-1:0]    tgt;
   logic [IDX_W-1:0]    slot;
   logic [KEY_W-1:0]    key;
   logic [CNT_W-1:0]    cnt_field;
   logic [CNT_W-1:0]    cnt_sat;
   logic [CNT_W-1:0]    cnt_sel;
   logic [CNT_W-1:0]    cnt_last;
   logic                tgt_ok;
   logic                accept;
   logic                busy;
   ibs_req_type         sreq;
   ibs_res_type         sres;

   logic [CNT_W-1:0]    count_ff [TARGET_COUNT];
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]    rsp_found_ff, rsp_found_in;

   assign op        = opcode_type'(req_tuser);
   assign tgt       = req_tdata[TGT_LSB +: TGT_W];
   assign slot      = req_tdata[SLOT_LSB +: IDX_W];
   assign key       = req_tdata[KEY_LSB +: KEY_W];
   assign cnt_field = req_tdata[CNT_LSB +: CNT_W];

   assign tgt_ok   = (32'(tgt) < TARGET_COUNT);
   assign cnt_sel  = tgt_ok ? count_ff[tgt] : '0;
   assign cnt_last = cnt_sel - CNT_W'(1);
   assign cnt_sat  = (cnt_field > CNT_W'(ENTRIES_PER_TARGET)) ?
                     CNT_W'(ENTRIES_PER_TARGET) : cnt_field;

   assign req_tready = !busy && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      sreq.start  = accept && (op == OP_QUERY) && (cnt_sel >= CNT_W'(2));
      sreq.wr_en  = accept && (op == OP_WRITE) && tgt_ok;
      sreq.target = tgt;
      sreq.index  = (op == OP_WRITE) ? slot : cnt_last[IDX_W-1:0];
      sreq.key    = key;
   end

   ibs_search u_search (
      .clock (clock),
      .reset (reset),
      .req   (sreq),
      .busy  (busy),
      .res   (sres)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      if (sres.done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = sres.oob ? ST_OOB : ST_OK;
         rsp_found_in  = sres.found;
      end else if (accept && !sreq.start) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = '0;
         rsp_status_in = ST_OK;
         if (op == OP_QUERY) begin
            rsp_status_in = (cnt_sel == '0) ? ST_EMPTY : ST_SHORT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TARGET_COUNT; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept && (op == OP_COUNT) && tgt_ok) begin
            count_ff[tgt] <= cnt_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_found_ff);
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- verif/interval_binary_search_test.sv -----
// Self-checking testbench for the interval binary search block
`timescale 1ns / 1ps

module interval_binary_search_test;
   import ibs_pkg::*;

   typedef struct {
      status_type       status;
      logic [IDX_W-1:0] found;
   } lookup_result_type;

   typedef enum {RX_READY, RX_COIN, RX_SPARSE} rx_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0]             req_tuser = OP_NONE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;

   logic signed [KEY_W-1:0] bp_shadow [TARGET_COUNT][ENTRIES_PER_TARGET];
   bit                      slot_written [TARGET_COUNT][ENTRIES_PER_TARGET];
   logic [CNT_W-1:0]        count_shadow [TARGET_COUNT];
   lookup_result_type       expected_results [$];

   int          error_count = 0;
   int unsigned results_seen = 0;
   int unsigned items_sent = 0;
   int unsigned burst_left = 0;
   bit          gap_enable = 1'b1;
   rx_mode_type rx_mode = RX_READY;
   int unsigned rx_left = 0;

   interval_binary_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial forever #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [KEY_W-1:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t ns, result %0d: %s", $time, results_seen, msg);
      error_count++;
   endtask

   function automatic lookup_result_type predict_lookup(logic [TGT_W-1:0] t,
                                                        logic signed [KEY_W-1:0] k);
      lookup_result_type r;
      int first;
      int last;
      int mid;
      r.status = ST_OK;
      r.found  = '0;
      if (count_shadow[t] == 0) begin
         r.status = ST_EMPTY;
      end else if (count_shadow[t] == 1) begin
         r.status = ST_SHORT;
      end else begin
         first = 0;
         last  = int'(count_shadow[t]) - 1;
         mid   = (first + last) >> 1;
         if (!(bp_shadow[t][first] <= k && k < bp_shadow[t][last])) begin
            r.status = ST_OOB;
         end else begin
            while (first != mid && mid != last) begin
               if (bp_shadow[t][first] <= k && k < bp_shadow[t][mid])
                  last = mid;
               else
                  first = mid;
               mid = (first + last) >> 1;
            end
            r.found = first[IDX_W-1:0];
         end
      end
      return r;
   endfunction

   function automatic bit table_readable(logic [TGT_W-1:0] t);
      if (count_shadow[t] < 2)
         return 1'b1;
      for (int i = 0; i < int'(count_shadow[t]); i++)
         if (!slot_written[t][i])
            return 1'b0;
      return 1'b1;
   endfunction

   task automatic record_item(opcode_type op, logic [TGT_W-1:0] t, logic [IDX_W-1:0] s,
                              logic [KEY_W-1:0] k, logic [CNT_W-1:0] c);
      lookup_result_type r;
      r.status = ST_OK;
      r.found  = '0;
      case (op)
         OP_WRITE: begin
            bp_shadow[t][s]    = k;
            slot_written[t][s] = 1'b1;
         end
         OP_COUNT: begin
            count_shadow[t] = (c > ENTRIES_PER_TARGET) ? CNT_W'(ENTRIES_PER_TARGET) : c;
         end
         OP_QUERY: begin
            r = predict_lookup(t, k);
         end
         default: begin
         end
      endcase
      expected_results = {expected_results, r};
   endtask

   task automatic send_item(opcode_type op, logic [TGT_W-1:0] t, logic [IDX_W-1:0] s,
                            logic [KEY_W-1:0] k, logic [CNT_W-1:0] c);
      int unsigned gap;
      logic [REQ_TDATA_W-1:0] d;
      if (gap_enable && burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left != 0)
         burst_left--;
      d = '0;
      d[TGT_LSB +: TGT_W]  = t;
      d[SLOT_LSB +: IDX_W] = s;
      d[KEY_LSB +: KEY_W]  = k;
      d[CNT_LSB +: CNT_W]  = c;
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      record_item(op, t, s, k, c);
      if (op != OP_NONE)
         items_sent++;
   endtask

   task automatic write_breakpoint(logic [TGT_W-1:0] t, logic [IDX_W-1:0] s,
                                   logic [KEY_W-1:0] k);
      send_item(OP_WRITE, t, s, k, CNT_W'($urandom));
   endtask

   task automatic set_count(logic [TGT_W-1:0] t, logic [CNT_W-1:0] c);
      send_item(OP_COUNT, t, IDX_W'($urandom), rand_key(), c);
   endtask

   // fall back to an unused opcode where the search could touch an unwritten slot
   task automatic issue_query(logic [TGT_W-1:0] t, logic [KEY_W-1:0] k);
      if (table_readable(t))
         send_item(OP_QUERY, t, IDX_W'($urandom), k, CNT_W'($urandom));
      else
         send_item(OP_NONE, t, IDX_W'($urandom), k, CNT_W'($urandom));
   endtask

   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 2));
         rx_left <= $urandom_range(64, 256);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         RX_READY: rsp_tready <= 1'b1;
         RX_COIN:  rsp_tready <= 1'($urandom_range(0, 1));
         default:  rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with nothing outstanding");
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_tuser, want.status));
            if (rsp_tdata !== want.found)
               report_mismatch($sformatf("found_index %0d, want %0d", rsp_tdata, want.found));
         end
         results_seen++;
      end
   end

   task automatic test_empty_targets();
      issue_query(4'd0, rand_key());
      send_item(OP_NONE, 4'd15, 8'hFF, rand_key(), 9'h1FF);
      set_count(4'd1, 9'd1);
      issue_query(4'd1, rand_key());
   endtask

   task automatic test_extreme_keys();
      write_breakpoint(4'd2, 8'd0, 64'h8000_0000_0000_0000);
      write_breakpoint(4'd2, 8'd1, 64'h0);
      write_breakpoint(4'd2, 8'd2, 64'h7FFF_FFFF_FFFF_FFFF);
      set_count(4'd2, 9'd3);
      issue_query(4'd2, 64'h8000_0000_0000_0000);
      issue_query(4'd2, 64'hFFFF_FFFF_FFFF_FFFF);
      issue_query(4'd2, 64'h0);
      issue_query(4'd2, 64'h7FFF_FFFF_FFFF_FFFE);
      issue_query(4'd2, 64'h7FFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_bounds();
      write_breakpoint(4'd3, 8'd0, 64'd10);
      write_breakpoint(4'd3, 8'd1, 64'd20);
      set_count(4'd3, 9'd2);
      issue_query(4'd3, 64'd9);
      issue_query(4'd3, 64'd19);
      issue_query(4'd3, 64'd20);
      set_count(4'd4, 9'h1FF);
      set_count(4'd4, 9'd257);
   endtask

   task automatic test_unsorted();
      write_breakpoint(4'd5, 8'd0, 64'd50);
      write_breakpoint(4'd5, 8'd1, 64'd10);
      write_breakpoint(4'd5, 8'd2, 64'd40);
      write_breakpoint(4'd5, 8'd3, 64'd60);
      set_count(4'd5, 9'd4);
      issue_query(4'd5, 64'd45);
      issue_query(4'd5, 64'd55);
   endtask

   task automatic build_table(int n);
      logic [TGT_W-1:0] t;
      longint           keys [$];
      longint           base;
      longint           k;
      bit               narrow;
      int               idx;
      int               nq;
      t      = TGT_W'($urandom);
      narrow = ($urandom_range(0, 9) < 3);
      base   = longint'(rand_key());
      for (int i = 0; i < n; i++) begin
         k    = narrow ? base + longint'($urandom_range(0, 40)) : longint'(rand_key());
         keys = {keys, k};
      end
      if ($urandom_range(0, 9) != 0)
         keys.sort();
      if ($urandom_range(0, 1) == 0) begin
         for (int i = 0; i < n; i++)
            write_breakpoint(t, IDX_W'(i), keys[i]);
      end else begin
         for (int i = n - 1; i >= 0; i--)
            write_breakpoint(t, IDX_W'(i), keys[i]);
      end
      if (n == ENTRIES_PER_TARGET && $urandom_range(0, 1) == 0)
         set_count(t, CNT_W'($urandom_range(257, 511)));
      else
         set_count(t, CNT_W'(n));
      nq = $urandom_range(3, 10);
      for (int q = 0; q < nq; q++) begin
         if (n == 0) begin
            k = longint'(rand_key());
         end else begin
            idx = $urandom_range(0, n - 1);
            case ($urandom_range(0, 6))
               0: k = keys[idx];
               1: k = keys[idx] - 1;
               2: k = keys[idx] + 1;
               3: k = (idx < n - 1) ? (keys[idx] >>> 1) + (keys[idx + 1] >>> 1) : keys[idx];
               4: k = keys[0] - longint'($urandom_range(0, 3));
               5: k = keys[n - 1] + longint'($urandom_range(0, 3)) - 1;
               default: k = longint'(rand_key());
            endcase
         end
         issue_query(t, k);
      end
   endtask

   task automatic send_noise();
      logic [TGT_W-1:0] t;
      t = TGT_W'($urandom);
      case ($urandom_range(0, 3))
         0: send_item(OP_NONE, t, IDX_W'($urandom), rand_key(), CNT_W'($urandom));
         1: set_count(t, CNT_W'($urandom_range(0, 511)));
         2: write_breakpoint(t, IDX_W'($urandom), rand_key());
         default: issue_query(t, rand_key());
      endcase
   endtask

   task automatic test_random();
      int unsigned start;
      int          n;
      int          pick;
      start = items_sent;
      build_table(ENTRIES_PER_TARGET);
      while (items_sent - start < 1250) begin
         gap_enable = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 99) < 65) begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
               n = $urandom_range(2, 16);
            else if (pick < 93)
               n = $urandom_range(0, 1);
            else if (pick < 98)
               n = $urandom_range(17, 255);
            else
               n = ENTRIES_PER_TARGET;
            build_table(n);
         end else begin
            repeat ($urandom_range(1, 5)) send_noise();
         end
      end
   endtask

   initial begin
      for (int t = 0; t < TARGET_COUNT; t++) begin
         count_shadow[t] = '0;
         for (int s = 0; s < ENTRIES_PER_TARGET; s++)
            slot_written[t][s] = 1'b0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_targets();
      test_extreme_keys();
      test_bounds();
      test_unsorted();
      test_random();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
